### rtl/core/union_find_connectivity_defines.svh
// assertion macros for the union-find connectivity block
// included by the top level only, no other dependencies
`ifndef UNION_FIND_CONNECTIVITY_DEFINES_SVH
`define UNION_FIND_CONNECTIVITY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define UF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uf same-cycle check failed");

// next-cycle implication, disabled during reset
`define UF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uf next-cycle check failed");

`else

`define UF_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define UF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/uf_pkg.sv
// shared types and constants for the union-find connectivity block
// no dependencies; used by uf_ctrl, uf_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package uf_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned ITEM_W    = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned UNION_W   = 10;
  localparam int unsigned PAIR_W    = 16;

  localparam logic [CNT_W-1:0]   ITEM_COUNT_RST = CNT_W'(MAX_ITEMS);
  localparam logic [UNION_W-1:0] UNIONS_MAX     = '1;
  localparam logic [PAIR_W-1:0]  PAIRS_MAX      = '1;

  typedef enum logic {
    OP_CONNECT = 1'b0,
    OP_CLEAR   = 1'b1
  } uf_op_e;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_OOR,
    K_JOINED,
    K_MERGED
  } uf_kind_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CHK1,
    S_FIND_CHK2,
    S_SIZE_P,
    S_SIZE_Q,
    S_UNION,
    S_RESP
  } uf_state_e;

  typedef struct packed {
    logic              operation;
    logic [ITEM_W-1:0] first_item;
    logic [ITEM_W-1:0] second_item;
  } uf_in_t;

  typedef struct packed {
    logic               already_joined;
    logic               merged;
    logic               out_of_range;
    logic [UNION_W-1:0] union_total;
    logic [PAIR_W-1:0]  pair_total;
    logic               all_joined;
  } uf_out_t;

  typedef struct packed {
    logic     load_in;
    logic     clear_cnt;
    logic     sweep_wr;
    logic     walk_first;
    logic     walk_second;
    logic     rd_node;
    logic     save_root;
    logic     side;
    logic     hop1;
    logic     hop2;
    logic     size_rd_p;
    logic     size_rd_q;
    logic     union_wr;
    logic     load_out;
    uf_kind_e kind;
  } uf_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic oor;
    logic walk_root;
    logic same_root;
    logic sweep_last;
    logic out_free;
  } uf_stat_t;

endpackage

`default_nettype wire

### rtl/core/uf_ctrl.sv
// sequencing state machine for the union-find block
// depends on uf_pkg; drives uf_dp through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module uf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  uf_pkg::uf_stat_t stat_i,
  output uf_pkg::uf_cmd_t  cmd_o
);

  uf_pkg::uf_state_e state_q, state_d;
  uf_pkg::uf_kind_e  kind_q, kind_d;
  logic              side_q, side_d;
  logic              clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uf_pkg::S_SWEEP;
      kind_q  <= uf_pkg::K_CLEAR;
      side_q  <= 1'b0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      side_q  <= side_d;
      clr_q   <= clr_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    side_d  = side_q;
    clr_d   = clr_q;
    case (state_q)
      uf_pkg::S_SWEEP: begin
        if (stat_i.sweep_last) begin
          state_d = clr_q ? uf_pkg::S_RESP : uf_pkg::S_IDLE;
        end
      end
      uf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = uf_pkg::S_DECODE;
        end
      end
      uf_pkg::S_DECODE: begin
        if (stat_i.is_clear) begin
          clr_d   = 1'b1;
          kind_d  = uf_pkg::K_CLEAR;
          state_d = uf_pkg::S_SWEEP;
        end else if (stat_i.oor) begin
          kind_d  = uf_pkg::K_OOR;
          state_d = uf_pkg::S_RESP;
        end else begin
          side_d  = 1'b0;
          state_d = uf_pkg::S_FIND_RD;
        end
      end
      uf_pkg::S_FIND_RD: begin
        state_d = uf_pkg::S_FIND_CHK1;
      end
      uf_pkg::S_FIND_CHK1: begin
        if (stat_i.walk_root) begin
          if (!side_q) begin
            side_d  = 1'b1;
            state_d = uf_pkg::S_FIND_RD;
          end else if (stat_i.same_root) begin
            kind_d  = uf_pkg::K_JOINED;
            state_d = uf_pkg::S_RESP;
          end else begin
            state_d = uf_pkg::S_SIZE_P;
          end
        end else begin
          state_d = uf_pkg::S_FIND_CHK2;
        end
      end
      uf_pkg::S_FIND_CHK2: begin
        state_d = uf_pkg::S_FIND_CHK1;
      end
      uf_pkg::S_SIZE_P: begin
        state_d = uf_pkg::S_SIZE_Q;
      end
      uf_pkg::S_SIZE_Q: begin
        state_d = uf_pkg::S_UNION;
      end
      uf_pkg::S_UNION: begin
        kind_d  = uf_pkg::K_MERGED;
        state_d = uf_pkg::S_RESP;
      end
      uf_pkg::S_RESP: begin
        if (stat_i.out_free) begin
          clr_d   = 1'b0;
          state_d = uf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = uf_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    cmd_o.side = side_q;
    in_stall_o = 1'b1;
    case (state_q)
      uf_pkg::S_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
      end
      uf_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      uf_pkg::S_DECODE: begin
        if (stat_i.is_clear) begin
          cmd_o.clear_cnt = 1'b1;
        end else if (!stat_i.oor) begin
          cmd_o.walk_first = 1'b1;
        end
      end
      uf_pkg::S_FIND_RD: begin
        cmd_o.rd_node = 1'b1;
      end
      uf_pkg::S_FIND_CHK1: begin
        if (stat_i.walk_root) begin
          cmd_o.save_root   = 1'b1;
          cmd_o.walk_second = !side_q;
        end else begin
          cmd_o.hop1 = 1'b1;
        end
      end
      uf_pkg::S_FIND_CHK2: begin
        cmd_o.hop2 = 1'b1;
      end
      uf_pkg::S_SIZE_P: begin
        cmd_o.size_rd_p = 1'b1;
      end
      uf_pkg::S_SIZE_Q: begin
        cmd_o.size_rd_q = 1'b1;
      end
      uf_pkg::S_UNION: begin
        cmd_o.union_wr = 1'b1;
      end
      uf_pkg::S_RESP: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o.load_in = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/uf_dp.sv
// datapath of the union-find block: parent and size memories, walk registers,
// counters, item count register and result register; depends on uf_pkg
`timescale 1ns / 1ps
`default_nettype none

module uf_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [uf_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  uf_pkg::uf_in_t            in_data_i,
  input  uf_pkg::uf_cmd_t           cmd_i,
  output uf_pkg::uf_stat_t          stat_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output uf_pkg::uf_out_t           out_data_o
);

  localparam int unsigned IW = uf_pkg::ITEM_W;
  localparam int unsigned CW = uf_pkg::CNT_W;
  localparam int unsigned SW = uf_pkg::SIZE_W;
  localparam int unsigned UW = uf_pkg::UNION_W;
  localparam int unsigned PW = uf_pkg::PAIR_W;

  logic [IW-1:0] parent_mem [uf_pkg::MAX_ITEMS];
  logic [SW-1:0] size_mem   [uf_pkg::MAX_ITEMS];

  logic [CW-1:0]   item_count_q;
  uf_pkg::uf_in_t  req_q;
  logic [IW-1:0]   node_q, node_d;
  logic [IW-1:0]   rp_q, rq_q;
  logic [SW-1:0]   sp_q;
  logic [IW-1:0]   parent_dout_q;
  logic [SW-1:0]   size_dout_q;
  logic [IW-1:0]   sweep_q;
  logic [UW-1:0]   unions_q, unions_d;
  logic [PW-1:0]   pairs_q, pairs_d;
  uf_pkg::uf_out_t out_q, out_d;
  logic            out_valid_q;

  logic [CW-1:0] eff_cnt;
  logic          p_small;
  logic [IW-1:0] small_root, big_root;
  logic [SW-1:0] size_sum;
  logic          sweep_last;
  logic          out_free;

  logic          par_we, par_re;
  logic [IW-1:0] par_wa, par_wd, par_ra;
  logic          sz_we, sz_re;
  logic [IW-1:0] sz_wa, sz_ra;
  logic [SW-1:0] sz_wd;

  assign eff_cnt    = (item_count_q > CW'(uf_pkg::MAX_ITEMS)) ? CW'(uf_pkg::MAX_ITEMS)
                                                             : item_count_q;
  assign sweep_last = (sweep_q == IW'(uf_pkg::MAX_ITEMS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign p_small    = (sp_q < size_dout_q);
  assign small_root = p_small ? rp_q : rq_q;
  assign big_root   = p_small ? rq_q : rp_q;
  assign size_sum   = sp_q + size_dout_q;

  always_comb begin
    stat_o.is_clear   = (req_q.operation == uf_pkg::OP_CLEAR);
    stat_o.oor        = ({1'b0, req_q.first_item} >= eff_cnt) ||
                        ({1'b0, req_q.second_item} >= eff_cnt);
    stat_o.walk_root  = (parent_dout_q == node_q);
    stat_o.same_root  = (rp_q == node_q);
    stat_o.sweep_last = sweep_last;
    stat_o.out_free   = out_free;
  end

  // parent memory port selection
  always_comb begin
    par_we = 1'b0;
    par_wa = node_q;
    par_wd = parent_dout_q;
    par_re = 1'b0;
    par_ra = node_q;
    if (cmd_i.sweep_wr) begin
      par_we = 1'b1;
      par_wa = sweep_q;
      par_wd = sweep_q;
    end
    if (cmd_i.rd_node) begin
      par_re = 1'b1;
      par_ra = node_q;
    end
    if (cmd_i.hop1) begin
      par_re = 1'b1;
      par_ra = parent_dout_q;
    end
    if (cmd_i.hop2) begin
      par_we = 1'b1;
      par_wa = node_q;
      par_wd = parent_dout_q;
      par_re = 1'b1;
      par_ra = parent_dout_q;
    end
    if (cmd_i.union_wr) begin
      par_we = 1'b1;
      par_wa = small_root;
      par_wd = big_root;
    end
  end

  // size memory port selection
  always_comb begin
    sz_we = 1'b0;
    sz_wa = big_root;
    sz_wd = size_sum;
    sz_re = 1'b0;
    sz_ra = rp_q;
    if (cmd_i.sweep_wr) begin
      sz_we = 1'b1;
      sz_wa = sweep_q;
      sz_wd = SW'(1);
    end
    if (cmd_i.size_rd_p) begin
      sz_re = 1'b1;
      sz_ra = rp_q;
    end
    if (cmd_i.size_rd_q) begin
      sz_re = 1'b1;
      sz_ra = rq_q;
    end
    if (cmd_i.union_wr) begin
      sz_we = 1'b1;
      sz_wa = big_root;
      sz_wd = size_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      parent_mem[par_wa] <= par_wd;
    end
    if (par_re) begin
      parent_dout_q <= parent_mem[par_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sz_we) begin
      size_mem[sz_wa] <= sz_wd;
    end
    if (sz_re) begin
      size_dout_q <= size_mem[sz_ra];
    end
  end

  // walk registers
  always_comb begin
    node_d = node_q;
    if (cmd_i.walk_first) begin
      node_d = req_q.first_item;
    end else if (cmd_i.walk_second) begin
      node_d = req_q.second_item;
    end else if (cmd_i.hop2) begin
      node_d = parent_dout_q;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    if (cmd_i.load_in) begin
      req_q <= in_data_i;
    end
    if (cmd_i.save_root) begin
      if (cmd_i.side) begin
        rq_q <= node_q;
      end else begin
        rp_q <= node_q;
      end
    end
    if (cmd_i.size_rd_q) begin
      sp_q <= size_dout_q;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  // counters and result
  always_comb begin
    unions_d = unions_q;
    pairs_d  = pairs_q;
    if (cmd_i.clear_cnt) begin
      unions_d = '0;
      pairs_d  = '0;
    end else if (cmd_i.load_out) begin
      if ((cmd_i.kind == uf_pkg::K_JOINED || cmd_i.kind == uf_pkg::K_MERGED) &&
          pairs_q != uf_pkg::PAIRS_MAX) begin
        pairs_d = pairs_q + PW'(1);
      end
      if (cmd_i.kind == uf_pkg::K_MERGED && unions_q != uf_pkg::UNIONS_MAX) begin
        unions_d = unions_q + UW'(1);
      end
    end
  end

  always_comb begin
    out_d.already_joined = (cmd_i.kind == uf_pkg::K_JOINED);
    out_d.merged         = (cmd_i.kind == uf_pkg::K_MERGED);
    out_d.out_of_range   = (cmd_i.kind == uf_pkg::K_OOR);
    out_d.union_total    = unions_d;
    out_d.pair_total     = pairs_d;
    out_d.all_joined     = (eff_cnt != '0) && ({1'b0, unions_d} == (eff_cnt - CW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= uf_pkg::ITEM_COUNT_RST;
      sweep_q      <= '0;
      unions_q     <= '0;
      pairs_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        item_count_q <= cfg_wdata_i;
      end
      if (cmd_i.sweep_wr) begin
        sweep_q <= sweep_last ? '0 : sweep_q + IW'(1);
      end
      unions_q <= unions_d;
      pairs_q  <= pairs_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/union_find_connectivity.sv
// top level of the union-find connectivity block (weighted union, path halving)
// depends on uf_pkg, uf_ctrl, uf_dp and union_find_connectivity_defines.svh
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  uf_in_t   in_data_i
//   out      output     out_valid_o/out_stall_i uf_out_t out_data_o
//   cfg      input      cfg_we_i               item_count cfg_wdata_i
//
// one request at a time; the single read port of the parent memory sets the pace
// connect: both root walks through the parent memory, then size reads and a union write; shorter when already joined
// clear or reset: a pass over all 1024 entries rewrites both memories, input stalled meanwhile
// the next request is taken while a result still waits in the output register
`timescale 1ns / 1ps
`default_nettype none

`include "union_find_connectivity_defines.svh"

module union_find_connectivity (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [uf_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  uf_pkg::uf_in_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output uf_pkg::uf_out_t          out_data_o
);

  uf_pkg::uf_cmd_t  cmd;
  uf_pkg::uf_stat_t stat;

  uf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  uf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `UF_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `UF_ASSERT_SAME(a_flags_excl, clk_i, rst_ni, out_valid_o, !(out_data_o.already_joined && out_data_o.merged) && !(out_data_o.out_of_range && (out_data_o.merged || out_data_o.already_joined)))
  `UF_ASSERT_SAME(a_merge_counted, clk_i, rst_ni, out_valid_o && out_data_o.merged, out_data_o.union_total != '0)

endmodule

`default_nettype wire

### bench/uf_checker.sv
// scoreboard for the union-find connectivity block: watches the cfg, in and out channels
// keeps its own forest, predicts each result and compares it field by field
// depends on uf_pkg only
`timescale 1ns / 1ps

module uf_checker
  import uf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  uf_in_t                  in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  uf_out_t                 out_data_i,
  output int unsigned             pending_o,
  output int unsigned             fail_count_o
);

  logic [ITEM_W-1:0]  link_q [MAX_ITEMS];
  logic [SIZE_W-1:0]  size_q [MAX_ITEMS];
  logic [UNION_W-1:0] unions_seen;
  logic [PAIR_W-1:0]  pairs_seen;
  logic [CNT_W-1:0]   item_count;

  uf_out_t expected_results [$];
  uf_out_t want;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic void clear_forest();
    for (int k = 0; k < MAX_ITEMS; k++) begin
      link_q[k] = ITEM_W'(k);
      size_q[k] = SIZE_W'(1);
    end
    unions_seen = '0;
    pairs_seen  = '0;
  endfunction

  // walk to the root, relinking every other node on the path to its grandparent
  function automatic logic [ITEM_W-1:0] root_of(logic [ITEM_W-1:0] node);
    while (node != link_q[node]) begin
      link_q[node] = link_q[link_q[node]];
      node = link_q[node];
    end
    return node;
  endfunction

  function automatic uf_out_t predict_outcome(uf_in_t req);
    uf_out_t           res;
    int unsigned       n;
    logic [ITEM_W-1:0] rp;
    logic [ITEM_W-1:0] rq;
    res = '0;
    n = (item_count > MAX_ITEMS) ? MAX_ITEMS : item_count;
    if (req.operation == OP_CLEAR) begin
      clear_forest();
    end else if (req.first_item >= n || req.second_item >= n) begin
      res.out_of_range = 1'b1;
    end else begin
      rp = root_of(req.first_item);
      rq = root_of(req.second_item);
      if (pairs_seen != PAIRS_MAX) pairs_seen++;
      if (rp == rq) begin
        res.already_joined = 1'b1;
      end else begin
        res.merged = 1'b1;
        if (unions_seen != UNIONS_MAX) unions_seen++;
        // smaller tree goes under the larger, ties to the first root
        if (size_q[rp] < size_q[rq]) begin
          link_q[rp] = rq;
          size_q[rq] = size_q[rq] + size_q[rp];
        end else begin
          link_q[rq] = rp;
          size_q[rp] = size_q[rp] + size_q[rq];
        end
      end
    end
    res.union_total = unions_seen;
    res.pair_total  = pairs_seen;
    res.all_joined  = (n > 0) && (unions_seen == n - 1);
    return res;
  endfunction

  task automatic check_field(input string label, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t uf_checker: %s expected %0d actual %0d", $time, label, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_forest();
      item_count = ITEM_COUNT_RST;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) item_count = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t uf_checker: result with none expected, actual %p", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("already_joined", want.already_joined, out_data_i.already_joined);
          check_field("merged", want.merged, out_data_i.merged);
          check_field("out_of_range", want.out_of_range, out_data_i.out_of_range);
          check_field("union_total", want.union_total, out_data_i.union_total);
          check_field("pair_total", want.pair_total, out_data_i.pair_total);
          check_field("all_joined", want.all_joined, out_data_i.all_joined);
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_outcome(in_data_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

### bench/tb.sv
// top of the union-find connectivity bench: clock, reset, cfg writes and request stimulus
// drives directed then random requests with random idling; uf_checker gives the fail count
// depends on uf_pkg, uf_checker and union_find_connectivity
`timescale 1ns / 1ps

module tb;
  import uf_pkg::*;

  localparam int unsigned STALL_LIMIT = 8000;
  localparam int unsigned PHASES      = 9;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  uf_in_t           in_data   = '0;
  logic             out_stall = 1'b0;
  logic             calm      = 1'b0;
  logic             in_stall;
  logic             out_valid;
  uf_out_t          out_data;
  int unsigned      pending;
  int unsigned      fail_count;
  int unsigned      idle_cycles = 0;
  int unsigned      active_count = ITEM_COUNT_RST;
  int unsigned      phase_count [PHASES];
  int unsigned      phase_items [PHASES];

  union_find_connectivity DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  uf_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // ends the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic uf_in_t make_req(input uf_op_e op, input int unsigned p,
                                      input int unsigned q);
    uf_in_t r;
    r.operation   = op;
    r.first_item  = ITEM_W'(p);
    r.second_item = ITEM_W'(q);
    return r;
  endfunction

  task automatic push_request(input uf_in_t req);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // let every outstanding request come back and the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
  endtask

  task automatic set_item_count(input int unsigned value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_count = (value > MAX_ITEMS) ? MAX_ITEMS : value;
  endtask

  initial begin
    int unsigned n;
    int unsigned roll;
    int unsigned hot;
    int unsigned p;
    int unsigned q;
    int unsigned t;

    phase_count = '{1024, 64, 2047, 8, 0, 1, 2, 700, 1024};
    phase_items = '{400, 200, 250, 100, 30, 30, 40, 300, 150};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    set_item_count(ITEM_COUNT_RST);
    push_request(make_req(OP_CONNECT, 0, 1023));
    push_request(make_req(OP_CONNECT, 1023, 0));
    push_request(make_req(OP_CONNECT, 5, 5));
    push_request(make_req(OP_CONNECT, 1022, 1021));
    push_request(make_req(OP_CONNECT, 0, 1022));
    push_request(make_req(OP_CLEAR, 1023, 1023));
    push_request(make_req(OP_CONNECT, 1023, 0));
    // shrunk count: item 0 already hangs under 1023
    set_item_count(4);
    push_request(make_req(OP_CONNECT, 4, 0));
    push_request(make_req(OP_CONNECT, 0, 1023));
    push_request(make_req(OP_CONNECT, 0, 1));
    push_request(make_req(OP_CONNECT, 2, 3));
    push_request(make_req(OP_CONNECT, 1, 3));
    push_request(make_req(OP_CONNECT, 3, 0));
    push_request(make_req(OP_CLEAR, 0, 0));
    set_item_count(0);
    push_request(make_req(OP_CONNECT, 0, 0));
    push_request(make_req(OP_CLEAR, 512, 1));
    set_item_count(1);
    push_request(make_req(OP_CLEAR, 0, 1023));
    push_request(make_req(OP_CONNECT, 0, 0));
    push_request(make_req(OP_CONNECT, 0, 1));
    set_item_count(2047);
    push_request(make_req(OP_CONNECT, 1023, 1022));
    push_request(make_req(OP_CONNECT, 1023, 512));
    push_request(make_req(OP_CONNECT, 0, 1023));

    // random part, one phase per item count setting
    for (int ph = 0; ph < PHASES; ph++) begin
      set_item_count(phase_count[ph]);
      calm <= (ph == 2);
      n   = active_count;
      hot = (n < 32) ? n : 32;
      if ($urandom_range(1)) push_request(make_req(OP_CLEAR, $urandom, $urandom));
      for (int i = 0; i < phase_items[ph]; i++) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          push_request(make_req(OP_CLEAR, $urandom, $urandom));
        end else if (n == 0 || (roll < 10 && n < MAX_ITEMS)) begin
          p = (n == 0) ? $urandom_range(MAX_ITEMS - 1) : $urandom_range(MAX_ITEMS - 1, n);
          q = $urandom_range(MAX_ITEMS - 1);
          if ($urandom_range(1)) begin
            t = p;
            p = q;
            q = t;
          end
          push_request(make_req(OP_CONNECT, p, q));
        end else begin
          p = $urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(hot - 1);
          q = $urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(hot - 1);
          push_request(make_req(OP_CONNECT, p, q));
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
